>>> src/assert_macros.svh
// assertion macros included by bitmap_gap_finder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, switched off while reset is held
`define AM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked property, also during reset
`define AM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/bgf_pkg.sv
// types, codes and helpers of the bitmap gap finder
package bgf_pkg;

    localparam int WORD_BITS = 64;
    localparam int BIT_POS_W = 6;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_SET   = 2'd1;
    localparam logic [1:0] KIND_FIND  = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SET_WR,
        ST_SCAN,
        ST_RESP
    } state_t;

    // result transfer, packed so that gap_found sits in bit 0
    typedef struct packed {
        logic        range_error;
        logic [12:0] next_offset;
        logic [12:0] gap_len;
        logic [11:0] gap_start;
        logic        gap_found;
    } result_t;

    // window of one word to examine
    typedef struct packed {
        logic                 in_run;
        logic [BIT_POS_W-1:0] lo;
        logic [BIT_POS_W:0]   hi;
    } scan_ctl_t;

    // outcome of examining one word
    typedef struct packed {
        logic                 zero_hit;
        logic [BIT_POS_W-1:0] zero_pos;
        logic                 set_hit;
        logic [BIT_POS_W-1:0] set_pos;
    } scan_res_t;

    // lowest set bit: {hit, position}
    function automatic logic [BIT_POS_W:0] first_one(input logic [WORD_BITS-1:0] v);
        logic                 hit;
        logic [BIT_POS_W-1:0] pos;
        hit = 1'b0;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                hit = 1'b1;
                pos = BIT_POS_W'(i);
            end
        end
        return {hit, pos};
    endfunction

endpackage

>>> src/bgf_ram.sv
// generic single-port-write, single-port-read ram with registered read
module bgf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/bgf_word_scan.sv
// finds the first clear bit and the following set bit within one bitmap word
module bgf_word_scan (
    input  logic [bgf_pkg::WORD_BITS-1:0] word_i,
    input  bgf_pkg::scan_ctl_t            ctl_i,
    output bgf_pkg::scan_res_t            res_o
);

    logic [bgf_pkg::WORD_BITS-1:0] win_mask;
    logic [bgf_pkg::WORD_BITS-1:0] above_mask;
    logic [bgf_pkg::BIT_POS_W:0]   zero_enc;
    logic [bgf_pkg::BIT_POS_W:0]   set_enc;
    logic [bgf_pkg::BIT_POS_W-1:0] zero_pos;

    always_comb begin
        for (int i = 0; i < bgf_pkg::WORD_BITS; i++) begin
            win_mask[i] = ((bgf_pkg::BIT_POS_W+1)'(i) >= {1'b0, ctl_i.lo}) &&
                          ((bgf_pkg::BIT_POS_W+1)'(i) < ctl_i.hi);
        end
    end

    assign zero_enc = bgf_pkg::first_one(~word_i & win_mask);

    // inside a run the run simply carries on from the window start
    assign zero_pos = ctl_i.in_run ? ctl_i.lo : zero_enc[bgf_pkg::BIT_POS_W-1:0];

    always_comb begin
        for (int i = 0; i < bgf_pkg::WORD_BITS; i++) begin
            above_mask[i] = (bgf_pkg::BIT_POS_W'(i) >= zero_pos);
        end
    end

    assign set_enc = bgf_pkg::first_one(word_i & win_mask & above_mask);

    assign res_o.zero_hit = ctl_i.in_run | zero_enc[bgf_pkg::BIT_POS_W];
    assign res_o.zero_pos = zero_pos;
    assign res_o.set_hit  = set_enc[bgf_pkg::BIT_POS_W];
    assign res_o.set_pos  = set_enc[bgf_pkg::BIT_POS_W-1:0];

endmodule

>>> src/bitmap_gap_finder.sv
// one item at a time; a find scan or a clear walks the ram one word per cycle
// a set rewrites its one word; a find stops at the end of the first gap or at the block end
// reset: aresetn low clears control state; afterwards a sweep of all bitmap words
// zeroes the ram with s_axis_tready low, results never wait on it
module bitmap_gap_finder #(
    parameter int BITMAP_WORDS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // bit_index[11:0], region_base[23:12], region_len[36:24], scan_offset[49:37], zero pad
    input  logic [55:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // gap_found[0], gap_start[12:1], gap_len[25:13], next_offset[38:26], range_error[39]
    output logic [39:0] m_axis_tdata
);

    `include "assert_macros.svh"

    localparam int STORE_BITS = BITMAP_WORDS * bgf_pkg::WORD_BITS;
    localparam int PW_MIN     = 14;
    localparam int PW = ($clog2(STORE_BITS + 1) > PW_MIN) ? $clog2(STORE_BITS + 1) : PW_MIN;
    localparam int WA = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int BP = bgf_pkg::BIT_POS_W;
    localparam logic [PW-1:0] STORE_END = PW'(STORE_BITS);
    localparam logic [WA-1:0] LAST_WORD = WA'(BITMAP_WORDS - 1);

    bgf_pkg::state_t state_reg, state_next;

    logic [WA-1:0]   word_reg, word_next;
    logic [BP-1:0]   lo_reg, lo_next;
    logic [BP-1:0]   setpos_reg, setpos_next;
    logic [11:0]     base_reg, base_next;
    logic [PW-1:0]   end_reg, end_next;
    logic            in_run_reg, in_run_next;
    logic [PW-1:0]   run_start_reg, run_start_next;
    logic [PW-1:0]   run_reg, run_next;
    bgf_pkg::result_t res_reg, res_next;
    bgf_pkg::result_t out_reg;
    logic            m_valid_reg;

    // input fields
    logic [1:0]  in_kind;
    logic [11:0] in_bit;
    logic [11:0] in_base;
    logic [12:0] in_size;
    logic [12:0] in_rel;

    assign in_kind = s_axis_tuser;
    assign in_bit  = s_axis_tdata[11:0];
    assign in_base = s_axis_tdata[23:12];
    assign in_size = s_axis_tdata[36:24];
    assign in_rel  = s_axis_tdata[49:37];

    logic [PW-1:0] start_pos;
    logic [PW-1:0] end_raw;
    logic [PW-1:0] end_sat;
    logic [PW-1:0] bit_ext;
    logic          set_ok;

    assign start_pos = PW'(in_base) + PW'(in_rel);
    assign end_raw   = PW'(in_base) + PW'(in_size);
    assign end_sat   = (end_raw > STORE_END) ? STORE_END : end_raw;
    assign bit_ext   = PW'(in_bit);
    assign set_ok    = bit_ext < STORE_END;

    // ram
    logic                          ram_we;
    logic [WA-1:0]                 ram_raddr;
    logic [bgf_pkg::WORD_BITS-1:0] ram_wdata;
    logic [bgf_pkg::WORD_BITS-1:0] ram_rdata;

    bgf_ram #(
        .WIDTH(bgf_pkg::WORD_BITS),
        .DEPTH(BITMAP_WORDS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(word_reg),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // per-word scan
    logic [PW-1:0]       word_base;
    logic [PW-1:0]       next_base;
    logic [PW-1:0]       end_dist;
    bgf_pkg::scan_ctl_t  scan_ctl;
    bgf_pkg::scan_res_t  scan_res;

    assign word_base = PW'({word_reg, {BP{1'b0}}});
    assign next_base = word_base + PW'(bgf_pkg::WORD_BITS);
    assign end_dist  = end_reg - word_base;

    assign scan_ctl.in_run = in_run_reg;
    assign scan_ctl.lo     = lo_reg;
    assign scan_ctl.hi     = (end_dist >= PW'(bgf_pkg::WORD_BITS)) ?
                             (BP+1)'(bgf_pkg::WORD_BITS) : end_dist[BP:0];

    bgf_word_scan u_scan (
        .word_i(ram_rdata),
        .ctl_i (scan_ctl),
        .res_o (scan_res)
    );

    logic [PW-1:0] scan_run;
    logic [PW-1:0] scan_run_start;
    logic [PW-1:0] scan_stop;
    logic          scan_done;
    bgf_pkg::result_t scan_result;

    always_comb begin
        scan_run_start = in_run_reg ? run_start_reg
                       : word_base + PW'(scan_res.zero_pos) - PW'(base_reg);
        if (scan_res.zero_hit && scan_res.set_hit) begin
            scan_run  = run_reg + PW'(scan_res.set_pos - scan_res.zero_pos);
            scan_stop = word_base + PW'(scan_res.set_pos);
            scan_done = 1'b1;
        end else begin
            scan_run  = scan_res.zero_hit ?
                        run_reg + PW'(scan_ctl.hi - {1'b0, scan_res.zero_pos}) : run_reg;
            scan_stop = end_reg;
            scan_done = next_base >= end_reg;
        end
        scan_result.gap_found   = scan_res.zero_hit;
        scan_result.gap_start   = scan_res.zero_hit ? scan_run_start[11:0] : 12'd0;
        scan_result.gap_len     = scan_run[12:0];
        scan_result.next_offset = 13'(scan_stop - PW'(base_reg));
        scan_result.range_error = 1'b0;
    end

    logic out_free;
    logic s_accept;

    assign out_free = !m_valid_reg || m_axis_tready;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bgf_pkg::ST_INIT: begin
                if (word_reg == LAST_WORD) state_next = bgf_pkg::ST_IDLE;
            end
            bgf_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    case (in_kind)
                        bgf_pkg::KIND_CLEAR: state_next = bgf_pkg::ST_CLEAR;
                        bgf_pkg::KIND_SET:
                            state_next = set_ok ? bgf_pkg::ST_SET_WR : bgf_pkg::ST_RESP;
                        bgf_pkg::KIND_FIND:
                            state_next = (start_pos < end_sat) ? bgf_pkg::ST_SCAN
                                                               : bgf_pkg::ST_RESP;
                        default: state_next = bgf_pkg::ST_RESP;
                    endcase
                end
            end
            bgf_pkg::ST_CLEAR: begin
                if (word_reg == LAST_WORD) state_next = bgf_pkg::ST_RESP;
            end
            bgf_pkg::ST_SET_WR: state_next = bgf_pkg::ST_RESP;
            bgf_pkg::ST_SCAN: begin
                if (scan_done) state_next = bgf_pkg::ST_RESP;
            end
            bgf_pkg::ST_RESP: begin
                if (out_free) state_next = bgf_pkg::ST_IDLE;
            end
            default: state_next = bgf_pkg::ST_INIT;
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_wdata     = '0;
        ram_raddr     = word_reg;
        case (state_reg)
            bgf_pkg::ST_INIT, bgf_pkg::ST_CLEAR: ram_we = 1'b1;
            bgf_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                ram_raddr = (in_kind == bgf_pkg::KIND_FIND) ? start_pos[WA+BP-1:BP]
                                                            : bit_ext[WA+BP-1:BP];
            end
            bgf_pkg::ST_SET_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | ({{(bgf_pkg::WORD_BITS-1){1'b0}}, 1'b1} << setpos_reg);
            end
            // fetch the following word while this one is examined
            bgf_pkg::ST_SCAN: ram_raddr = word_reg + WA'(1);
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        word_next      = word_reg;
        lo_next        = lo_reg;
        setpos_next    = setpos_reg;
        base_next      = base_reg;
        end_next       = end_reg;
        in_run_next    = in_run_reg;
        run_start_next = run_start_reg;
        run_next       = run_reg;
        res_next       = res_reg;
        case (state_reg)
            bgf_pkg::ST_INIT, bgf_pkg::ST_CLEAR: begin
                word_next = (word_reg == LAST_WORD) ? '0 : word_reg + WA'(1);
            end
            bgf_pkg::ST_IDLE: begin
                if (s_accept) begin
                    res_next       = '0;
                    setpos_next    = bit_ext[BP-1:0];
                    lo_next        = start_pos[BP-1:0];
                    base_next      = in_base;
                    end_next       = end_sat;
                    in_run_next    = 1'b0;
                    run_start_next = '0;
                    run_next       = '0;
                    case (in_kind)
                        bgf_pkg::KIND_CLEAR: word_next = '0;
                        bgf_pkg::KIND_SET:   word_next = bit_ext[WA+BP-1:BP];
                        bgf_pkg::KIND_FIND: begin
                            word_next = start_pos[WA+BP-1:BP];
                            // empty scan or start past the block end
                            res_next.next_offset = in_rel;
                            res_next.range_error = start_pos > end_sat;
                        end
                        default: ;
                    endcase
                end
            end
            bgf_pkg::ST_SCAN: begin
                word_next      = word_reg + WA'(1);
                lo_next        = '0;
                in_run_next    = scan_res.zero_hit;
                run_start_next = scan_res.zero_hit ? scan_run_start : run_start_reg;
                run_next       = scan_run;
                if (scan_done) res_next = scan_result;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bgf_pkg::ST_INIT;
            word_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            word_reg  <= word_next;
            if (state_reg == bgf_pkg::ST_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        setpos_reg    <= setpos_next;
        base_reg      <= base_next;
        end_reg       <= end_next;
        in_run_reg    <= in_run_next;
        run_start_reg <= run_start_next;
        run_reg       <= run_next;
        res_reg       <= res_next;
        if (state_reg == bgf_pkg::ST_RESP && out_free) begin
            out_reg <= res_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_reg;

    `AM_ASSERT(a_result_from_resp, aclk, aresetn, $rose(m_axis_tvalid) |-> $past(state_reg == bgf_pkg::ST_RESP), "result transfer raised outside the response state")
    `AM_ASSERT(a_no_write_in_scan, aclk, aresetn, (state_reg == bgf_pkg::ST_SCAN) |-> !ram_we, "ram written during a scan")
    `AM_ASSERT(a_scan_in_block, aclk, aresetn, (state_reg == bgf_pkg::ST_SCAN) |-> (word_base < end_reg), "scan word past the block end")

endmodule

>>> dv/bitmap_gap_finder_test.sv
// self-checking testbench of the bitmap gap finder: directed and random operations, stream stalls
module bitmap_gap_finder_test;
    import bgf_pkg::*;

    localparam int BITMAP_WORDS = 64;
    localparam int STORE_BITS   = BITMAP_WORDS * WORD_BITS;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    // own copy of the mark store
    logic [WORD_BITS-1:0] marks [BITMAP_WORDS];
    result_t awaited_results [$];

    int unsigned send_idle_pct  = 26;
    int unsigned recv_idle_pct  = 26;
    int unsigned hold_requests  = 0;
    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned gaps_seen      = 0;
    int unsigned range_errs     = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;

    bitmap_gap_finder #(
        .BITMAP_WORDS(BITMAP_WORDS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        foreach (marks[w]) marks[w] = '0;
    end

    // applies one operation to the mark store and returns the result it should give
    function automatic result_t apply_bitmap_op(input logic [1:0] kind,
            input logic [11:0] bit_index, input logic [11:0] region_base,
            input logic [12:0] region_len, input logic [12:0] scan_offset);
        result_t     r;
        int unsigned first;
        int unsigned stop;
        int unsigned b;
        int unsigned run;
        int unsigned run_at;
        bit          in_run;
        r      = '0;
        run    = 0;
        run_at = 0;
        in_run = 1'b0;
        case (kind)
            KIND_CLEAR: begin
                foreach (marks[w]) marks[w] = '0;
            end
            KIND_SET: begin
                if (bit_index < STORE_BITS)
                    marks[bit_index / WORD_BITS][bit_index % WORD_BITS] = 1'b1;
            end
            KIND_FIND: begin
                first = region_base + scan_offset;
                stop  = region_base + region_len;
                if (stop > STORE_BITS)
                    stop = STORE_BITS;
                if (first > stop) begin
                    r.next_offset = scan_offset;
                    r.range_error = 1'b1;
                end else begin
                    for (b = first; b < stop; b++) begin
                        if (!marks[b / WORD_BITS][b % WORD_BITS]) begin
                            if (!in_run) begin
                                in_run = 1'b1;
                                run_at = b - region_base;
                            end
                            run++;
                        end else if (in_run) begin
                            break;
                        end
                    end
                    r.gap_found   = in_run;
                    r.gap_start   = 12'(run_at);
                    r.gap_len     = 13'(run);
                    r.next_offset = 13'(b - region_base);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // offers one item and waits for its transfer; valid stays high afterwards
    task automatic send_item(input logic [1:0] kind, input logic [11:0] bit_index,
            input logic [11:0] region_base, input logic [12:0] region_len,
            input logic [12:0] scan_offset);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {6'b0, scan_offset, region_len, region_base, bit_index};
        do @(posedge aclk); while (!s_axis_tready);
        awaited_results.push_back(
            apply_bitmap_op(kind, bit_index, region_base, region_len, scan_offset));
        items_sent++;
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge aclk);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
            input int unsigned got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // receiver: random stalls, plus a long hold-off when one is requested
    initial begin : receiver
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = result_t'(m_axis_tdata);
            results_seen++;
            if (got.gap_found)
                gaps_seen++;
            if (got.range_error)
                range_errs++;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("gap_found", want.gap_found, got.gap_found);
                check_field("gap_start", want.gap_start, got.gap_start);
                check_field("gap_len", want.gap_len, got.gap_len);
                check_field("next_offset", want.next_offset, got.next_offset);
                check_field("range_error", want.range_error, got.range_error);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // edges of every field and the corner cases of the scan
    task automatic test_directed();
        send_item(KIND_FIND, 12'd0, 12'd0, 13'd4096, 13'd0);
        send_item(KIND_SET, 12'd0, 12'hfff, 13'h1fff, 13'h1fff);
        send_item(KIND_SET, 12'd4095, 12'd0, 13'd0, 13'd0);
        send_item(KIND_SET, 12'd63, 12'd0, 13'd0, 13'd0);
        send_item(KIND_SET, 12'd64, 12'd0, 13'd0, 13'd0);
        send_item(KIND_FIND, 12'd0, 12'd0, 13'd4096, 13'd0);
        send_item(KIND_FIND, 12'd0, 12'd0, 13'd4096, 13'd65);
        send_item(KIND_FIND, 12'd0, 12'd4095, 13'd1, 13'd0);
        send_item(KIND_FIND, 12'd0, 12'd4000, 13'd4096, 13'd0);
        send_item(KIND_FIND, 12'd0, 12'd4095, 13'd4096, 13'd4096);
        send_item(KIND_FIND, 12'd0, 12'd0, 13'd0, 13'd4096);
        send_item(KIND_FIND, 12'd0, 12'd100, 13'd10, 13'd10);
        send_item(KIND_FIND, 12'd0, 12'd100, 13'd10, 13'd11);
        send_item(KIND_FIND, 12'd0, 12'd0, 13'd0, 13'd0);
        send_item(KIND_FIND, 12'd0, 12'd62, 13'd4, 13'd0);
        send_item(KIND_FIND, 12'hfff, 12'd1, 13'd4096, 13'd4095);
        send_item(KIND_UNUSED, 12'hfff, 12'hfff, 13'd4096, 13'd4096);
        send_item(KIND_FIND, 12'd0, 12'd0, 13'd200, 13'd0);
        send_item(KIND_CLEAR, 12'hfff, 12'hfff, 13'd4096, 13'd4096);
        send_item(KIND_FIND, 12'd0, 12'd0, 13'd4096, 13'd0);
        send_item(KIND_FIND, 12'd0, 12'd4095, 13'd0, 13'd0);
        wait_all_results();
    endtask

    // clear now and then, mark bits inside a window, then scan blocks around it
    task automatic test_gap_sequences(input int unsigned item_target);
        int unsigned win_lo;
        int unsigned win_len;
        int unsigned n_sets;
        int unsigned base;
        int unsigned size;
        int unsigned rel;
        while (items_sent < item_target) begin
            if ($urandom_range(0, 1))
                send_item(KIND_CLEAR, 12'($urandom), 12'($urandom),
                          13'($urandom_range(0, 4096)), 13'($urandom_range(0, 4096)));
            if ($urandom_range(0, 19) == 0)
                win_len = $urandom_range(1, STORE_BITS);
            else
                win_len = $urandom_range(1, 192);
            win_lo = $urandom_range(0, STORE_BITS - win_len);
            n_sets = $urandom_range(0, win_len / 3 + 2);
            if (n_sets > 40)
                n_sets = 40;
            repeat (n_sets)
                send_item(KIND_SET, 12'(win_lo + $urandom_range(0, win_len - 1)),
                          12'($urandom), 13'($urandom_range(0, 4096)),
                          13'($urandom_range(0, 4096)));
            repeat ($urandom_range(2, 8)) begin
                base = win_lo + $urandom_range(0, win_len / 2);
                if (base > STORE_BITS - 1)
                    base = STORE_BITS - 1;
                if ($urandom_range(0, 15) == 0)
                    size = $urandom_range(3800, STORE_BITS);
                else
                    size = $urandom_range(0, win_len + 16);
                if (size > STORE_BITS)
                    size = STORE_BITS;
                case ($urandom_range(0, 9))
                    0: rel = size + $urandom_range(1, 64);
                    1: rel = size;
                    default: rel = $urandom_range(0, size);
                endcase
                if (rel > STORE_BITS)
                    rel = STORE_BITS;
                send_item(KIND_FIND, 12'($urandom), 12'(base), 13'(size), 13'(rel));
            end
        end
    endtask

    // items of any kind with unrelated fields
    task automatic test_noise(input int unsigned count);
        repeat (count)
            send_item(2'($urandom), 12'($urandom), 12'($urandom),
                      13'($urandom_range(0, 4096)), 13'($urandom_range(0, 4096)));
    endtask

    // receiver holds off while items keep coming, so the input stalls
    task automatic test_receiver_hold();
        hold_requests++;
        test_noise(30);
        wait_all_results();
    endtask

    // sender pauses until the result queue has drained, between two bursts
    task automatic test_drain_pause();
        test_noise(10);
        wait_all_results();
        test_gap_sequences(items_sent + 40);
        wait_all_results();
    endtask

    // a stretch with both sides always ready
    task automatic test_no_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_gap_sequences(items_sent + 150);
        wait_all_results();
        send_idle_pct = 26;
        recv_idle_pct = 26;
    endtask

    initial begin : main
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_gap_sequences(1000);
        test_receiver_hold();
        test_drain_pause();
        test_no_idle();
        test_noise(150);
        test_gap_sequences(1750);
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d items: clear, set, find and unused kinds with random stalls",
                 items_sent);
        $display("%0d results checked, %0d with a gap, %0d with a range error",
                 results_seen, gaps_seen, range_errs);
        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
